// File: sv/key_debounce_click_hold_repeat_macros.svh
// Assertion macros shared by the key debounce block.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef KEY_DEBOUNCE_CLICK_HOLD_REPEAT_MACROS_SVH
`define KEY_DEBOUNCE_CLICK_HOLD_REPEAT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define KDCHR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kdchr same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define KDCHR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kdchr next-cycle check failed");

`endif

// File: sv/kdchr_pkg.sv
// Package for the key debounce block: widths, phase codes, event kinds and types.
// No dependencies; used by key_debounce_click_hold_repeat.
package kdchr_pkg;

   localparam int unsigned KEY_W   = 4;
   localparam int unsigned TICK_W  = 8;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned CSR_IDX_W = 2;

   // Highest key code that counts as a press; larger codes read as no key.
   localparam logic [TICK_W-1:0] MAX_KEY = 8'd15;

   // Phase codes.
   localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
   localparam logic [PHASE_W-1:0] PH_DEBOUNCE  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_WAIT_HOLD = 2'd2;
   localparam logic [PHASE_W-1:0] PH_REPEAT    = 2'd3;

   // Event kinds.
   localparam logic EV_CLICK = 1'b0;
   localparam logic EV_HOLD  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT   = 2'd2;

   localparam logic [KEY_W-1:0] NO_KEY = '0;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] key;
   } event_type;

endpackage

// File: sv/key_debounce_click_hold_repeat.sv
// Key debounce with click, hold and auto-repeat events (top level).
// Depends on kdchr_pkg and key_debounce_click_hold_repeat_macros.svh.
//
//   Channel   Direction  Word contents
//   req_*     in         tdata[3:0] key_code, tdata[7:4] zero
//   rsp_*     out        tdata[3:0] event_key, tdata[7:4] zero; tuser[0] event_kind
//   csr_*     in         csr_we, csr_index (register), csr_wdata (8-bit value)
//
// One key word is taken per clock cycle while req_tready is high. The phase machine
// and its countdown update in the cycle the word is accepted, and an event lands on
// the same edge in the output register, or in the skid register if that one stays full.
// A skid register behind the output register lets the block keep taking key
// words while one event waits; req_tready drops only when both hold an event.
// Reset is synchronous and active high: phase goes idle, countdown clears,
// the timing registers return to 5, 100 and 20 ticks, and both event slots
// empty. The remembered key has no reset; a press writes it before any read.
`include "key_debounce_click_hold_repeat_macros.svh"

module key_debounce_click_hold_repeat (
   input  logic       clock,
   input  logic       reset,
   // Key input stream.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [3:0] key_code, [7:4] unused
   // Event output stream.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [3:0] event_key, [7:4] zero
   output logic       rsp_tuser,   // [0] event_kind
   // Configuration write port.
   input  logic       csr_we,
   input  logic [kdchr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kdchr_pkg::TICK_W-1:0]    csr_wdata
);

   // Timing registers.
   logic [kdchr_pkg::TICK_W-1:0] debounce_ff, hold_ff, repeat_ff;

   // Phase machine state.
   logic [kdchr_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [kdchr_pkg::TICK_W-1:0]  countdown_ff, countdown_in;
   logic [kdchr_pkg::KEY_W-1:0]   held_key_ff, held_key_in;

   // Output register and skid register.
   logic                 out_valid_ff, out_valid_in;
   kdchr_pkg::event_type out_ev_ff, out_ev_in;
   logic                 skid_valid_ff, skid_valid_in;
   kdchr_pkg::event_type skid_ev_ff, skid_ev_in;

   logic                          req_accept, rsp_take, out_free;
   logic [kdchr_pkg::KEY_W-1:0]   key;
   logic [kdchr_pkg::TICK_W-1:0]  count_dec;
   logic                          push;
   kdchr_pkg::event_type          push_ev;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;
   assign out_free   = !out_valid_ff || rsp_take;

   // Codes above the highest key are treated as no key at all.
   assign key = ({{(kdchr_pkg::TICK_W - kdchr_pkg::KEY_W){1'b0}},
                  req_tdata[kdchr_pkg::KEY_W-1:0]} > kdchr_pkg::MAX_KEY)
                ? kdchr_pkg::NO_KEY : req_tdata[kdchr_pkg::KEY_W-1:0];

   // On each accepted word the countdown steps first, then the phase logic may reload it.
   assign count_dec = (countdown_ff != '0) ? countdown_ff - 1'b1 : countdown_ff;

   always_comb begin
      phase_in     = phase_ff;
      countdown_in = countdown_ff;
      held_key_in  = held_key_ff;
      push         = 1'b0;
      push_ev.kind = kdchr_pkg::EV_CLICK;
      push_ev.key  = held_key_ff;
      if (req_accept) begin
         countdown_in = count_dec;
         if (key == kdchr_pkg::NO_KEY) begin
            // Release: only a release while waiting for hold is a click.
            if (phase_ff == kdchr_pkg::PH_WAIT_HOLD) begin
               push = 1'b1;
            end
            phase_in = kdchr_pkg::PH_IDLE;
         end else if (phase_ff == kdchr_pkg::PH_IDLE) begin
            phase_in     = kdchr_pkg::PH_DEBOUNCE;
            countdown_in = debounce_ff;
            held_key_in  = key;
         end else if (key != held_key_ff) begin
            // A different key cancels; it counts as a press next word.
            phase_in = kdchr_pkg::PH_IDLE;
         end else if (count_dec == '0) begin
            if (phase_ff == kdchr_pkg::PH_DEBOUNCE) begin
               phase_in     = kdchr_pkg::PH_WAIT_HOLD;
               countdown_in = hold_ff;
            end else begin
               phase_in     = kdchr_pkg::PH_REPEAT;
               countdown_in = repeat_ff;
               push         = 1'b1;
               push_ev.kind = kdchr_pkg::EV_HOLD;
            end
         end
      end
   end

   // Event slots: a new event goes straight to the output register when it
   // frees up this cycle, else it parks in the skid register.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_ev_in     = out_ev_ff;
      skid_valid_in = skid_valid_ff;
      skid_ev_in    = skid_ev_ff;
      if (push) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_ev_in    = push_ev;
         end else begin
            skid_valid_in = 1'b1;
            skid_ev_in    = push_ev;
         end
      end else if (rsp_take) begin
         out_valid_in  = skid_valid_ff;
         out_ev_in     = skid_ev_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= 8'd5;
         hold_ff       <= 8'd100;
         repeat_ff     <= 8'd20;
         phase_ff      <= kdchr_pkg::PH_IDLE;
         countdown_ff  <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               kdchr_pkg::CSR_DEBOUNCE: debounce_ff <= csr_wdata;
               kdchr_pkg::CSR_HOLD:     hold_ff     <= csr_wdata;
               kdchr_pkg::CSR_REPEAT:   repeat_ff   <= csr_wdata;
               default: ;
            endcase
         end
         phase_ff      <= phase_in;
         countdown_ff  <= countdown_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_key_ff <= held_key_in;
      out_ev_ff   <= out_ev_in;
      skid_ev_ff  <= skid_ev_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(8 - kdchr_pkg::KEY_W){1'b0}}, out_ev_ff.key};
   assign rsp_tuser  = out_ev_ff.kind;

   // The skid register only fills behind a waiting output event.
   `KDCHR_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)

   // Hold events come only from the wait-for-hold or auto-repeat phases.
   `KDCHR_ASSERT_NOW(a_hold_from_timed_phase, clock, reset, push && (push_ev.kind == kdchr_pkg::EV_HOLD), (phase_ff == kdchr_pkg::PH_WAIT_HOLD) || (phase_ff == kdchr_pkg::PH_REPEAT))

   // A released key always leaves the machine idle.
   `KDCHR_ASSERT_NEXT(a_release_idles, clock, reset, req_accept && (key == kdchr_pkg::NO_KEY), phase_ff == kdchr_pkg::PH_IDLE)

   // A press from idle starts debounce with the remembered key.
   `KDCHR_ASSERT_NEXT(a_press_debounces, clock, reset, req_accept && (key != kdchr_pkg::NO_KEY) && (phase_ff == kdchr_pkg::PH_IDLE), (phase_ff == kdchr_pkg::PH_DEBOUNCE) && (held_key_ff == $past(key)))

endmodule

// File: test/tb.sv
// Self-checking testbench for key_debounce_click_hold_repeat: key words in, events out.
// Depends on kdchr_pkg and the block itself; it builds its own tracker of the debounce phases.
module tb;

   // Receiver stall styles. Each style lasts for a random stretch of cycles.
   typedef enum logic [1:0] {RX_FREE, RX_PATTERN, RX_RANDOM, RX_SLOW} rx_mode_type;

   // Clock, reset and every block input start at known values.
   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [7:0]                            req_tdata = '0;   // [3:0] key_code, [7:4] zero
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [7:0]                            rsp_tdata;        // [3:0] event_key, [7:4] zero
   logic                                  rsp_tuser;        // [0] event_kind
   logic                                  csr_we = 1'b0;
   logic [kdchr_pkg::CSR_IDX_W-1:0]       csr_index = kdchr_pkg::CSR_DEBOUNCE;
   logic [kdchr_pkg::TICK_W-1:0]          csr_wdata = '0;

   // Key words still to be sent, and the events the tracker says must come out.
   logic [kdchr_pkg::KEY_W-1:0] key_words[$];
   kdchr_pkg::event_type        events_due[$];
   int                          words_queued = 0;
   int                          mismatches = 0;

   // The tracker's copy of the timing registers, starting at their reset values.
   logic [kdchr_pkg::TICK_W-1:0] tick_debounce = 8'd5;
   logic [kdchr_pkg::TICK_W-1:0] tick_hold = 8'd100;
   logic [kdchr_pkg::TICK_W-1:0] tick_repeat = 8'd20;

   // The tracker's copy of the phase machine. The remembered key is written by a
   // press before it is ever compared, so its starting value does not matter.
   logic [kdchr_pkg::PHASE_W-1:0] trk_phase = kdchr_pkg::PH_IDLE;
   logic [kdchr_pkg::TICK_W-1:0]  trk_count = '0;
   logic [kdchr_pkg::KEY_W-1:0]   trk_key = kdchr_pkg::NO_KEY;

   // Sender burst and gap bookkeeping, owned by the driver block.
   int burst_left = 0;
   int gap_left = 0;

   // Receiver stall bookkeeping, owned by the receiver block.
   rx_mode_type rx_mode = RX_FREE;
   int          rx_left = 0;
   int          rx_tick = 0;

   key_debounce_click_hold_repeat dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advances the tracker by one accepted key word. The countdown ticks first,
   // then the phase machine looks at the key. Returns 1 when an event is due.
   function automatic logic predict_event(input logic [kdchr_pkg::KEY_W-1:0] code,
                                          output kdchr_pkg::event_type ev);
      logic [kdchr_pkg::KEY_W-1:0] key;
      logic                        hit;
      key = code;
      hit = 1'b0;
      ev = '0;
      // Codes beyond the highest valid key read exactly like no key at all.
      if ({{(kdchr_pkg::TICK_W - kdchr_pkg::KEY_W){1'b0}}, key} > kdchr_pkg::MAX_KEY) begin
         key = kdchr_pkg::NO_KEY;
      end
      if (trk_count != '0) trk_count = trk_count - 1'b1;
      if (key == kdchr_pkg::NO_KEY) begin
         // Only a release while waiting for hold is a click; any other
         // release just drops back to idle.
         if (trk_phase == kdchr_pkg::PH_WAIT_HOLD) begin
            hit = 1'b1;
            ev.kind = kdchr_pkg::EV_CLICK;
            ev.key = trk_key;
         end
         trk_phase = kdchr_pkg::PH_IDLE;
      end else if (trk_phase == kdchr_pkg::PH_IDLE) begin
         trk_phase = kdchr_pkg::PH_DEBOUNCE;
         trk_count = tick_debounce;
         trk_key = key;
      end else if (key != trk_key) begin
         // A different key aborts silently; it is not a press until next word.
         trk_phase = kdchr_pkg::PH_IDLE;
      end else if (trk_count == '0) begin
         if (trk_phase == kdchr_pkg::PH_DEBOUNCE) begin
            trk_phase = kdchr_pkg::PH_WAIT_HOLD;
            trk_count = tick_hold;
         end else begin
            // End of the hold wait or of a repeat period: both fire a hold.
            trk_phase = kdchr_pkg::PH_REPEAT;
            trk_count = tick_repeat;
            hit = 1'b1;
            ev.kind = kdchr_pkg::EV_HOLD;
            ev.key = trk_key;
         end
      end
      return hit;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
   endtask

   // Driver. A new word is put on the bus only when the bus is empty or the
   // current word is being taken at this edge, so tvalid gets one assignment
   // per edge and stays high across back-to-back words within a burst.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (key_words.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {4'b0000, key_words.pop_front()};
            if (burst_left <= 1) begin
               // Start a fresh burst; a third of them follow with no gap at all.
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver. The stall style is redrawn whenever its stretch runs out, so both
   // long free-running stretches and heavy back-pressure occur.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_tick++;
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(30, 200);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            RX_FREE: begin
               rsp_tready <= 1'b1;
            end
            RX_PATTERN: begin
               rsp_tready <= (rx_tick % 5) < 3;
            end
            RX_RANDOM: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_tready <= (rx_tick % 4) == 0;
            end
         endcase
      end
   end

   // Monitor and scoreboard. An event leaving the block is checked against the
   // oldest expectation first; then a key word taken at this same edge is fed
   // to the tracker. An event can never come out in the cycle its word goes in.
   always @(posedge clock) begin
      kdchr_pkg::event_type want;
      kdchr_pkg::event_type ev;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (events_due.size() == 0) begin
               note_mismatch($sformatf("unexpected event kind %0d key %0d",
                                       rsp_tuser, rsp_tdata[3:0]));
            end else begin
               want = events_due.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata[3:0] !== want.key) begin
                  note_mismatch($sformatf(
                     "event expected kind %0d key %0d, got kind %0d key %0d",
                     want.kind, want.key, rsp_tuser, rsp_tdata[3:0]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (predict_event(req_tdata[kdchr_pkg::KEY_W-1:0], ev)) events_due.push_back(ev);
         end
      end
   end

   task automatic add_run(input logic [kdchr_pkg::KEY_W-1:0] key, input int count);
      repeat (count) key_words.push_back(key);
      words_queued += count;
   endtask

   // Waits until every queued word is taken and every expected event has
   // come out, then lets the output stage settle.
   task automatic settle();
      @(posedge clock);
      while (key_words.size() != 0 || req_tvalid || events_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; the tracker takes the new value at once, since it is
   // called only after settle(), when no key word is in flight.
   task automatic set_register(input logic [kdchr_pkg::CSR_IDX_W-1:0] idx,
                               input logic [kdchr_pkg::TICK_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         kdchr_pkg::CSR_DEBOUNCE: tick_debounce = value;
         kdchr_pkg::CSR_HOLD:     tick_hold = value;
         kdchr_pkg::CSR_REPEAT:   tick_repeat = value;
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [kdchr_pkg::TICK_W-1:0] db,
                             input logic [kdchr_pkg::TICK_W-1:0] hd,
                             input logic [kdchr_pkg::TICK_W-1:0] rp);
      set_register(kdchr_pkg::CSR_DEBOUNCE, db);
      set_register(kdchr_pkg::CSR_HOLD, hd);
      set_register(kdchr_pkg::CSR_REPEAT, rp);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Queues random key activity for the current timing until the phase has
   // about the given number of words. Press lengths are chosen around the
   // current debounce, hold and repeat times so that every phase is reached.
   task automatic fill_phase(input int budget);
      int                          start;
      int                          d;
      int                          h;
      int                          p;
      int                          pick;
      logic [kdchr_pkg::KEY_W-1:0] key;
      logic [kdchr_pkg::KEY_W-1:0] other;
      start = words_queued;
      d = tick_debounce;
      h = tick_hold;
      p = tick_repeat;
      while (words_queued - start < budget) begin
         pick = $urandom_range(0, 9);
         key = 4'($urandom_range(1, 15));
         case (pick)
            0, 1: begin
               // Short press that ends during debounce or right at its end.
               add_run(key, $urandom_range(1, d + 2));
            end
            2, 3: begin
               // Press that mostly reaches the hold wait and is released as a click.
               add_run(key, $urandom_range(d + 1, d + h + 2));
            end
            4, 5, 6: begin
               // Long press: a hold event and some repeats, release gives nothing.
               add_run(key, d + h + 2 + $urandom_range(0, 3 * (p + 1) + 2));
            end
            7: begin
               // The key changes while held, which must abort silently.
               other = 4'(((key - 1 + $urandom_range(1, 14)) % 15) + 1);
               add_run(key, $urandom_range(1, d + h + p + 3));
               add_run(other, $urandom_range(1, d + h + 3));
            end
            8: begin
               // Noise: arbitrary codes, releases included.
               repeat ($urandom_range(1, 8)) add_run(4'($urandom_range(0, 15)), 1);
            end
            default: begin
               // A bouncing contact, then a press that mostly settles into a click.
               repeat ($urandom_range(1, 3)) begin
                  add_run(key, $urandom_range(1, d + 1));
                  add_run(kdchr_pkg::NO_KEY, 1);
               end
               add_run(key, d + 2 + $urandom_range(0, h));
            end
         endcase
         if (pick != 8) add_run(kdchr_pkg::NO_KEY, $urandom_range(1, 3));
      end
   endtask

   // Stimulus sequence. Reset is held at the start, a directed part runs on
   // the reset timing, and then random phases follow, each on its own timing.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset timing (debounce 5, hold 100, repeat 20).
      // A release during debounce gives no event.
      add_run(4'd3, 2);
      add_run(kdchr_pkg::NO_KEY, 1);
      // A key change during debounce returns to idle with no event.
      add_run(4'd5, 1);
      add_run(4'd6, 2);
      add_run(kdchr_pkg::NO_KEY, 1);
      // The highest key held past debounce and released gives a click.
      add_run(4'd15, 7);
      add_run(kdchr_pkg::NO_KEY, 1);
      // A key change while waiting for hold aborts; the new key then starts
      // its own press on the following word and is released in debounce.
      add_run(4'd1, 7);
      add_run(4'd2, 2);
      add_run(kdchr_pkg::NO_KEY, 1);
      settle();

      // Random activity on the reset timing, long enough for holds and repeats.
      fill_phase(300);
      settle();

      // All times zero: every phase ends on the word after it starts.
      set_timing(8'd0, 8'd0, 8'd0);
      fill_phase(150);
      settle();

      // All times at their maximum: one press long enough for a hold and a
      // repeat, then a release that must not give a click.
      set_timing(8'd255, 8'd255, 8'd255);
      add_run(4'($urandom_range(1, 15)), 772);
      add_run(kdchr_pkg::NO_KEY, 2);
      settle();

      // Further phases on random short timings until the stimulus is used up.
      while (words_queued < 1950) begin
         set_timing(8'($urandom_range(0, 6)), 8'($urandom_range(0, 12)),
                    8'($urandom_range(0, 6)));
         fill_phase(120);
         settle();
      end

      if (events_due.size() != 0) begin
         note_mismatch($sformatf("%0d events never came, oldest kind %0d key %0d",
                                 events_due.size(), events_due[0].kind, events_due[0].key));
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
